@@ src/pcgrs_pkg.sv @@
// Shared types, constants and the output permutation of the PCG32 range sampler.
package pcgrs_pkg;

  localparam logic [63:0] LCG_MULT  = 64'd6364136223846793005;
  localparam logic [63:0] INC_RESET = 64'd1442695040888963407;

  typedef enum logic [1:0] {
    CMD_RESEED = 2'd0,
    CMD_RAW    = 2'd1,
    CMD_RANGE  = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_RESEED,
    ST_RAW,
    ST_LIMIT,
    ST_DRAW_HI,
    ST_DRAW_LO,
    ST_CHECK,
    ST_MOD,
    ST_FINISH
  } fsm_t;

  typedef enum logic [2:0] {
    PH_LO_LO,
    PH_HI_LO,
    PH_LO_HI,
    PH_ADD_CROSS,
    PH_ADD_INC
  } lcg_phase_t;

  // Status of a shared multi-cycle unit: busy while working, done for one cycle at the end.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // XSH-RR output permutation of the old state.
  function automatic logic [31:0] xsh_rr(input logic [63:0] old);
    logic [63:0] shifted;
    logic [31:0] mixed;
    logic [63:0] doubled;
    shifted = ((old >> 18) ^ old) >> 27;
    mixed   = shifted[31:0];
    doubled = {mixed, mixed} >> old[63:59];
    return doubled[31:0];
  endfunction

endpackage

@@ src/pcgrs_lcg.sv @@
// One LCG step and XSH-RR draw, with the 64-bit multiply split over a shared 32x32 multiplier.
module pcgrs_lcg
  import pcgrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] state_in,
  input  logic [63:0] increment,
  output unit_stat_t  stat,
  output logic [63:0] next_state,
  output logic [31:0] draw
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  lcg_phase_t  phase_r, phase_nxt;
  logic [63:0] st_r, st_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] draw_r, draw_nxt;
  logic [31:0] mul_a, mul_b;

  // Operand selection for the shared multiplier; only the low partial product
  // and the two cross products survive modulo 2^64.
  always_comb begin
    case (phase_r)
      PH_LO_LO: begin
        mul_a = st_r[31:0];
        mul_b = LCG_MULT[31:0];
      end
      PH_HI_LO: begin
        mul_a = st_r[63:32];
        mul_b = LCG_MULT[31:0];
      end
      PH_LO_HI: begin
        mul_a = st_r[31:0];
        mul_b = LCG_MULT[63:32];
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    phase_nxt = phase_r;
    st_nxt    = st_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    draw_nxt  = draw_r;
    if (start && !busy_r) begin
      busy_nxt  = 1'b1;
      phase_nxt = PH_LO_LO;
      st_nxt    = state_in;
      draw_nxt  = xsh_rr(state_in);
    end else if (busy_r) begin
      prod_nxt = {32'd0, mul_a} * {32'd0, mul_b};
      case (phase_r)
        PH_LO_LO: begin
          phase_nxt = PH_HI_LO;
        end
        PH_HI_LO: begin
          acc_nxt   = prod_r;
          phase_nxt = PH_LO_HI;
        end
        PH_LO_HI: begin
          acc_nxt   = acc_r + {prod_r[31:0], 32'd0};
          phase_nxt = PH_ADD_CROSS;
        end
        PH_ADD_CROSS: begin
          acc_nxt   = acc_r + {prod_r[31:0], 32'd0};
          phase_nxt = PH_ADD_INC;
        end
        PH_ADD_INC: begin
          acc_nxt  = acc_r + increment;
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= PH_LO_LO;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      phase_r <= phase_nxt;
    end
    st_r   <= st_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    draw_r <= draw_nxt;
  end

  assign stat.busy  = busy_r;
  assign stat.done  = done_r;
  assign next_state = acc_r;
  assign draw       = draw_r;

endmodule

@@ src/pcgrs_div.sv @@
// Restoring remainder unit, one quotient bit per cycle, for 64-bit operands.
module pcgrs_div
  import pcgrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output unit_stat_t  stat,
  output logic [63:0] remainder
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] dvd_r, dvd_nxt;
  logic [63:0] dvs_r, dvs_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [64:0] trial;

  assign trial = {rem_r, dvd_r[63]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '1;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = 64'd0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[62:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 64'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[63:0];
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

endmodule

@@ src/pcg32_range_sampler_core.sv @@
// Top level of the PCG32 range sampler: request sequencer, generator state and result register.
//
// Usage. A request enters on the in_ channel (in_valid high, in_stall low) and
// carries a command: reseed, raw 32-bit draw, or a draw in an inclusive range.
// Exactly one result leaves on the out_ channel for every request. The block
// handles one request at a time and holds in_stall high from acceptance until
// its result has been placed in the output register.
// A reseed or a raw draw takes one LCG step, which holds the sequencer while
// it runs on the shared 32x32 multiplier. A range draw takes two passes of the
// remainder unit (the rejection limit and the final reduction) and two LCG
// steps, and each rejected draw repeats the two LCG steps.
// A full 64-bit range skips both remainder passes; a reversed range reports
// range_error without touching the generator.
// The result register decouples the receiver: the block takes the next
// request while a result still waits; a request that finishes while the old
// result is stalled waits in its final state until the register frees.
// The user must write the increment register through cfg_ only while the block is
// idle; the block does not enforce this. Bit 0 is forced high. Reset loads it and
// the generator state with the standard PCG32 default increment and clears all control state.
module pcg32_range_sampler_core
  import pcgrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_seed_value,
  input  logic [63:0] in_range_min,
  input  logic [63:0] in_range_max,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_random_value,
  output logic        out_range_error,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data
);

  fsm_t        fsm_r, fsm_nxt;
  logic [63:0] inc_r, inc_nxt;
  logic [63:0] state_r, state_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [63:0] seed_r, seed_nxt;
  logic [63:0] lo_r, lo_nxt;
  logic [63:0] hi_r, hi_nxt;
  logic [63:0] span_r, span_nxt;
  logic        full_r, full_nxt;
  logic [63:0] limit_r, limit_nxt;
  logic [63:0] draw_r, draw_nxt;
  logic [63:0] value_r, value_nxt;
  logic        err_r, err_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_value_r, out_value_nxt;
  logic        out_err_r, out_err_nxt;

  logic        accept;
  logic        can_send;
  logic        range_bad;
  logic        range_full;
  logic        in_draw;
  logic        lcg_start;
  unit_stat_t  lcg_stat;
  logic [63:0] lcg_next;
  logic [31:0] lcg_draw;
  logic        div_start;
  logic [63:0] div_dividend;
  unit_stat_t  div_stat;
  logic [63:0] div_rem;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (fsm_r != ST_IDLE);
  assign can_send = !out_valid_r || !out_stall;

  // Range checks on the latched request; these feed the decision in the
  // preparation cycle.
  assign range_bad  = (lo_r > hi_r);
  assign range_full = (lo_r == 64'd0) && (hi_r == '1);

  assign in_draw = (fsm_r == ST_RESEED) || (fsm_r == ST_RAW) ||
                   (fsm_r == ST_DRAW_HI) || (fsm_r == ST_DRAW_LO);

  // A unit is started once on entry to a state that needs it; the done
  // cycle is excluded so that the leaving state does not restart it.
  assign lcg_start = in_draw && !lcg_stat.busy && !lcg_stat.done;
  assign div_start = ((fsm_r == ST_LIMIT) || (fsm_r == ST_MOD)) &&
                     !div_stat.busy && !div_stat.done;

  // The limit is (2^64 - span) mod span; the final reduction is draw mod span.
  assign div_dividend = (fsm_r == ST_LIMIT) ? (64'd0 - span_r) : draw_r;

  pcgrs_lcg u_lcg (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (lcg_start),
    .state_in  (state_r),
    .increment (inc_r),
    .stat      (lcg_stat),
    .next_state(lcg_next),
    .draw      (lcg_draw)
  );

  pcgrs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (span_r),
    .stat     (div_stat),
    .remainder(div_rem)
  );

  // Next state of the sequencer.
  always_comb begin
    fsm_nxt = fsm_r;
    case (fsm_r)
      ST_IDLE: begin
        if (accept) begin
          fsm_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        case (cmd_r)
          CMD_RESEED: fsm_nxt = ST_RESEED;
          CMD_RAW:    fsm_nxt = ST_RAW;
          CMD_RANGE: begin
            if (range_bad) begin
              fsm_nxt = ST_FINISH;
            end else if (range_full) begin
              fsm_nxt = ST_DRAW_HI;
            end else begin
              fsm_nxt = ST_LIMIT;
            end
          end
          default:    fsm_nxt = ST_FINISH;
        endcase
      end
      ST_RESEED, ST_RAW: begin
        if (lcg_stat.done) begin
          fsm_nxt = ST_FINISH;
        end
      end
      ST_LIMIT: begin
        if (div_stat.done) begin
          fsm_nxt = ST_DRAW_HI;
        end
      end
      ST_DRAW_HI: begin
        if (lcg_stat.done) begin
          fsm_nxt = ST_DRAW_LO;
        end
      end
      ST_DRAW_LO: begin
        if (lcg_stat.done) begin
          fsm_nxt = full_r ? ST_FINISH : ST_CHECK;
        end
      end
      ST_CHECK: begin
        fsm_nxt = (draw_r < limit_r) ? ST_DRAW_HI : ST_MOD;
      end
      ST_MOD: begin
        if (div_stat.done) begin
          fsm_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (can_send) begin
          fsm_nxt = ST_IDLE;
        end
      end
      default: fsm_nxt = ST_IDLE;
    endcase
  end

  // Datapath and result register updates.
  always_comb begin
    inc_nxt       = inc_r;
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    seed_nxt      = seed_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    span_nxt      = span_r;
    full_nxt      = full_r;
    limit_nxt     = limit_r;
    draw_nxt      = draw_r;
    value_nxt     = value_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;

    if (cfg_wr_en) begin
      inc_nxt = cfg_wr_data | 64'd1;
    end

    // Every finished LCG step moves the generator on.
    if (lcg_stat.done) begin
      state_nxt = lcg_next;
    end

    case (fsm_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_cmd;
          seed_nxt = in_seed_value;
          lo_nxt   = in_range_min;
          hi_nxt   = in_range_max;
        end
      end
      ST_PREP: begin
        value_nxt = 64'd0;
        span_nxt  = hi_r - lo_r + 64'd1;
        full_nxt  = range_full;
        err_nxt   = (cmd_r == CMD_RANGE) && range_bad;
        if (cmd_r == CMD_RESEED) begin
          state_nxt = seed_r + inc_r;
        end
      end
      ST_RAW: begin
        if (lcg_stat.done) begin
          value_nxt = {32'd0, lcg_draw};
        end
      end
      ST_LIMIT: begin
        if (div_stat.done) begin
          limit_nxt = div_rem;
        end
      end
      ST_DRAW_HI: begin
        if (lcg_stat.done) begin
          draw_nxt = {lcg_draw, draw_r[31:0]};
        end
      end
      ST_DRAW_LO: begin
        if (lcg_stat.done) begin
          draw_nxt = {draw_r[63:32], lcg_draw};
          if (full_r) begin
            value_nxt = {draw_r[63:32], lcg_draw};
          end
        end
      end
      ST_MOD: begin
        if (div_stat.done) begin
          value_nxt = lo_r + div_rem;
        end
      end
      ST_FINISH: begin
        if (can_send) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = value_r;
          out_err_nxt   = err_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= ST_IDLE;
      inc_r       <= INC_RESET;
      state_r     <= INC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      inc_r       <= inc_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    seed_r      <= seed_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    span_r      <= span_nxt;
    full_r      <= full_nxt;
    limit_r     <= limit_nxt;
    draw_r      <= draw_nxt;
    value_r     <= value_nxt;
    err_r       <= err_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;
  assign out_range_error  = out_err_r;

endmodule
